FILE: rtl/tga_rle_pkg.sv
`timescale 1ns / 1ps

package tga_rle_pkg;

    // Longest run that one packet may carry
    localparam int MAX_RUN_DEF = 127;

    // Output packet queue, a power of two
    localparam int QUEUE_DEPTH = 4;

    // Count byte pieces
    localparam logic [7:0] RUN_FLAG     = 8'h80;
    localparam logic [7:0] RUN_LEN_MASK = 8'h7F;
    localparam logic [7:0] SINGLE_COUNT = 8'h00;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COMPRESS = 1'b0,
        CFG_SWAP     = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic compress_enable;
        logic swap_red_blue;
    } t_cfg;

    // One output packet
    typedef struct packed {
        logic        has_count;
        logic [7:0]  count_byte;
        logic [31:0] out_color;
        logic        last_of_item;
        logic        image_done;
    } t_pkt;

    // RGBA to BGRA: trade bytes 0 and 2
    function automatic logic [31:0] swap_rb(input logic [31:0] color, input logic en);
        logic [31:0] res;
        res = en ? {color[31:24], color[7:0], color[15:8], color[23:16]} : color;
        return res;
    endfunction

endpackage

FILE: rtl/tga_rle_run.sv
`timescale 1ns / 1ps

module tga_rle_run #(
    parameter int MAX_RUN = tga_rle_pkg::MAX_RUN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tga_rle_pkg::t_cfg i_cfg,
    input  logic              i_accept,
    input  logic [31:0]       i_pixel_color,
    input  logic              i_row_end,
    input  logic              i_frame_end,
    output tga_rle_pkg::t_pkt o_pkt_a,
    output tga_rle_pkg::t_pkt o_pkt_b,
    output logic [1:0]        o_wr_cnt
);
    import tga_rle_pkg::*;

    localparam int LW = $clog2(MAX_RUN + 1);

    logic [31:0]   r_run_color;
    logic [LW-1:0] r_run_length;
    logic          r_run_open;
    logic [31:0]   n_run_color;
    logic [LW-1:0] n_run_length;
    logic          n_run_open;

    logic          hit;
    logic          closes;
    logic [31:0]   new_color;
    logic [LW-1:0] new_len;
    logic          v0;
    logic          v1;
    t_pkt          pkt0;
    t_pkt          pkt1;

    // Count byte for a run of the given length
    function automatic logic [7:0] count_of(input logic [LW-1:0] len);
        logic [7:0] len8;
        logic [7:0] res;
        len8 = 8'(len);
        if (len8 >= 8'd2) begin
            res = RUN_FLAG | ((len8 - 8'd1) & RUN_LEN_MASK);
        end else begin
            res = SINGLE_COUNT;
        end
        return res;
    endfunction

    // Run merge and packet build for the incoming pixel
    always_comb begin
        hit       = r_run_open && (i_pixel_color == r_run_color)
                    && (r_run_length < LW'(MAX_RUN));
        closes    = i_row_end | i_frame_end;
        new_color = hit ? r_run_color : i_pixel_color;
        new_len   = hit ? r_run_length + LW'(1) : LW'(1);

        // pending run, flushed ahead of the pixel
        pkt0.has_count  = 1'b1;
        pkt0.count_byte = count_of(r_run_length);
        pkt0.out_color  = swap_rb(r_run_color, i_cfg.swap_red_blue);

        if (i_cfg.compress_enable) begin
            v0              = r_run_open && !hit;
            v1              = closes;
            pkt1.has_count  = 1'b1;
            pkt1.count_byte = count_of(new_len);
            pkt1.out_color  = swap_rb(new_color, i_cfg.swap_red_blue);
            n_run_open      = !closes;
            n_run_length    = closes ? '0 : new_len;
            n_run_color     = new_color;
        end else begin
            v0              = r_run_open;
            v1              = 1'b1;
            pkt1.has_count  = 1'b0;
            pkt1.count_byte = SINGLE_COUNT;
            pkt1.out_color  = swap_rb(i_pixel_color, i_cfg.swap_red_blue);
            n_run_open      = 1'b0;
            n_run_length    = '0;
            n_run_color     = r_run_color;
        end

        // end marks go on the last packet of the item
        pkt0.last_of_item = !v1;
        pkt0.image_done   = !v1 && i_frame_end;
        pkt1.last_of_item = 1'b1;
        pkt1.image_done   = i_frame_end;

        o_pkt_a  = v0 ? pkt0 : pkt1;
        o_pkt_b  = pkt1;
        o_wr_cnt = i_accept ? {v0 & v1, v0 ^ v1} : 2'd0;
    end

    // Run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_color  <= '0;
            r_run_length <= '0;
            r_run_open   <= 1'b0;
        end else if (i_accept) begin
            r_run_color  <= n_run_color;
            r_run_length <= n_run_length;
            r_run_open   <= n_run_open;
        end
    end

endmodule

FILE: rtl/tga_rle_pkt_queue.sv
`timescale 1ns / 1ps

module tga_rle_pkt_queue (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic [1:0]                                   i_wr_cnt,
    input  tga_rle_pkg::t_pkt                            i_pkt_a,
    input  tga_rle_pkg::t_pkt                            i_pkt_b,
    input  logic                                         i_pop,
    output tga_rle_pkg::t_pkt                            o_head,
    output logic [$clog2(tga_rle_pkg::QUEUE_DEPTH+1)-1:0] o_level
);
    import tga_rle_pkg::*;

    localparam int PW  = $clog2(QUEUE_DEPTH);
    localparam int LVW = $clog2(QUEUE_DEPTH + 1);

    t_pkt           r_slot [QUEUE_DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [LVW-1:0] r_level;
    logic [PW-1:0]  n_wr_ptr;
    logic [PW-1:0]  n_rd_ptr;
    logic [LVW-1:0] n_level;
    logic [PW-1:0]  wr_ptr_b;

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_b = r_wr_ptr + PW'(1);
        n_wr_ptr = r_wr_ptr + PW'(i_wr_cnt);
        n_rd_ptr = r_rd_ptr + PW'(i_pop);
        n_level  = r_level + LVW'(i_wr_cnt) - LVW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

    // Up to two packets written per cycle
    always_ff @(posedge i_clk) begin
        if (i_wr_cnt != 2'd0) begin
            r_slot[r_wr_ptr] <= i_pkt_a;
        end
        if (i_wr_cnt == 2'd2) begin
            r_slot[wr_ptr_b] <= i_pkt_b;
        end
    end

    assign o_head  = r_slot[r_rd_ptr];
    assign o_level = r_level;

endmodule

FILE: rtl/tga_rle_pixel_encoder_core.sv
`timescale 1ns / 1ps

// Run-length pixel encoder for TGA-style image data. Pixels enter one per
// cycle on the slave stream while s_axis_tready is high; each accepted
// pixel is merged into the current run in the same cycle, and the packets
// it causes (none, one or two) are written into a four-entry packet queue
// that drives the master stream, so a packet is registered in the queue
// before it leaves. Sustained rate is one pixel per cycle while each pixel
// yields at most one packet and m_axis_tready stays high; s_axis_tready
// drops while the queue has fewer than two free entries. A configuration
// write takes effect at once, so write the registers only while the stream
// is idle and the queue is empty.
module tga_rle_pixel_encoder_core #(
    parameter int MAX_RUN = tga_rle_pkg::MAX_RUN_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_wr_en,
    input  logic [tga_rle_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic                                i_cfg_wr_data,
    // pixel stream in
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [31:0]                         s_axis_tdata,  // [31:0] pixel_color
    input  logic                                s_axis_tlast,  // frame_end
    input  logic [0:0]                          s_axis_tuser,  // [0] row_end
    // packet stream out
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [39:0]                         m_axis_tdata,  // [7:0] count_byte, [39:8] out_color
    output logic                                m_axis_tlast,  // image_done
    output logic [1:0]                          m_axis_tuser   // [0] has_count, [1] last_of_item
);
    import tga_rle_pkg::*;

    localparam int LVW = $clog2(QUEUE_DEPTH + 1);

    logic           r_compress_enable;
    logic           r_swap_red_blue;
    t_cfg           cfg;
    logic           in_accept;
    logic           out_pop;
    logic [1:0]     wr_cnt;
    t_pkt           pkt_a;
    t_pkt           pkt_b;
    t_pkt           head;
    logic [LVW-1:0] level;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_compress_enable <= 1'b1;
            r_swap_red_blue   <= 1'b1;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_COMPRESS: r_compress_enable <= i_cfg_wr_data;
                CFG_SWAP:     r_swap_red_blue   <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign cfg.compress_enable = r_compress_enable;
    assign cfg.swap_red_blue   = r_swap_red_blue;

    // Handshakes: take a pixel only with room for two packets
    assign s_axis_tready = i_rst_n && (level <= LVW'(QUEUE_DEPTH - 2));
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (level != '0);
    assign out_pop       = m_axis_tvalid && m_axis_tready;

    tga_rle_run #(
        .MAX_RUN (MAX_RUN)
    ) u_run (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_accept      (in_accept),
        .i_pixel_color (s_axis_tdata),
        .i_row_end     (s_axis_tuser[0]),
        .i_frame_end   (s_axis_tlast),
        .o_pkt_a       (pkt_a),
        .o_pkt_b       (pkt_b),
        .o_wr_cnt      (wr_cnt)
    );

    tga_rle_pkt_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_cnt (wr_cnt),
        .i_pkt_a  (pkt_a),
        .i_pkt_b  (pkt_b),
        .i_pop    (out_pop),
        .o_head   (head),
        .o_level  (level)
    );

    // Output packing
    assign m_axis_tdata = {head.out_color, head.count_byte};
    assign m_axis_tlast = head.image_done;
    assign m_axis_tuser = {head.last_of_item, head.has_count};

    // Queue never overfills
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        level <= LVW'(QUEUE_DEPTH))
        else $error("packet queue level above depth");

    // Raw pixels and row or frame ends always leave at least one packet
    a_item_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (!r_compress_enable || s_axis_tlast || s_axis_tuser[0]))
        |-> (wr_cnt != 2'd0))
        else $error("accepted pixel produced no packet");

    // Queue level tracks writes and pops
    a_level_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (level == $past(level) + LVW'($past(wr_cnt)) - LVW'($past(out_pop))))
        else $error("packet queue level out of step");

    // Packets are never written without an accepted pixel
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_accept |-> (wr_cnt == 2'd0))
        else $error("packet written without a pixel");

endmodule
